@@ rtl/escape_sequence_unescaper_defines.svh @@
// ----------------------------------------------------------------------------
// Escape sequence unescaper - assertion macros
// Shared concurrent assertion forms for the unescaper RTL.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_UNESCAPER_DEFINES_SVH
`define ESCAPE_SEQUENCE_UNESCAPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ESU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("esu assertion failed");

// Next-cycle implication, disabled during reset.
`define ESU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("esu assertion failed");

`endif

@@ rtl/esu_pkg.sv @@
// ----------------------------------------------------------------------------
// esu_pkg
// Types and constants shared by the escape sequence unescaper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package esu_pkg;

    // Group queue between decoder and serializer
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [3:0] {
        PH_START       = 4'd0,
        PH_SAW_M       = 4'd1,
        PH_AFTER_MDASH = 4'd2,
        PH_SKIPWS      = 4'd3,
        PH_PLAIN       = 4'd4,
        PH_BSLASH      = 4'd5,
        PH_OCTAL       = 4'd6,
        PH_CARET       = 4'd7
    } t_phase;

    // Decoded words caused by one input word
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } t_group;

endpackage

`default_nettype wire

@@ rtl/esu_front.sv @@
// ----------------------------------------------------------------------------
// esu_front
// Decoder: accepts raw words, tracks escape state, emits result groups.
// ----------------------------------------------------------------------------
`default_nettype none

module esu_front import esu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output logic            o_push,
    output t_group          o_group
);

    t_phase          r_phase, n_phase;
    logic [7:0]      r_acc, n_acc;
    logic [1:0]      r_dig, n_dig;
    logic            r_meta, n_meta;
    logic [7:0]      r_last_emit, n_last_emit;

    logic            pre_v;
    logic [7:0]      pre_b;
    logic            do_plain;
    logic [2:0][7:0] e_buf;
    logic [1:0]      e_cnt;
    logic [7:0]      acc2;
    logic [1:0]      dig2;
    logic [7:0]      caret_c;
    logic            is_oct;
    logic            is_ws;

    always_comb begin
        is_oct  = i_byte inside {[8'h30:8'h37]};
        is_ws   = (i_byte == 8'h20) || (i_byte inside {[8'h09:8'h0D]});
        acc2    = {r_acc[4:0], i_byte[2:0]};
        dig2    = r_dig + 2'd1;
        caret_c = i_byte;
        if (i_byte inside {[8'h61:8'h7A]}) begin
            caret_c = i_byte - CASE_GAP;
        end
        if (caret_c == CH_QUEST) begin
            caret_c = CH_DEL;
        end else begin
            caret_c = caret_c - CH_AT;
        end

        n_phase     = r_phase;
        n_acc       = r_acc;
        n_dig       = r_dig;
        n_meta      = r_meta;
        n_last_emit = r_last_emit;
        pre_v       = 1'b0;
        pre_b       = i_byte;
        do_plain    = 1'b0;
        e_buf       = '0;
        e_cnt       = 2'd0;

        case (r_phase)
            PH_START: begin
                if (i_byte == CH_M) n_phase = PH_SAW_M;
                else                do_plain = 1'b1;
            end
            PH_SAW_M: begin
                pre_v = 1'b1;
                if (i_byte == CH_DASH) begin
                    pre_b   = CH_ESC;
                    n_phase = PH_AFTER_MDASH;
                end else begin
                    pre_b    = CH_M;
                    do_plain = 1'b1;
                end
            end
            PH_AFTER_MDASH: begin
                if (i_byte == CH_X_UP || i_byte == CH_X_LO) begin
                    pre_v   = 1'b1;
                    pre_b   = CH_X_LO;
                    n_meta  = 1'b1;
                    n_phase = PH_SKIPWS;
                end else begin
                    do_plain = 1'b1;
                end
            end
            PH_SKIPWS: begin
                if (!is_ws) do_plain = 1'b1;
            end
            PH_BSLASH: begin
                if (is_oct) begin
                    n_acc   = {5'd0, i_byte[2:0]};
                    n_dig   = 2'd1;
                    n_phase = PH_OCTAL;
                end else begin
                    pre_v   = 1'b1;
                    n_phase = PH_PLAIN;
                    case (i_byte)
                        8'h61:        pre_b = CH_BEL;
                        8'h62:        pre_b = CH_BS;
                        8'h65, 8'h45: pre_b = CH_ESC;
                        8'h6E:        pre_b = CH_LF;
                        8'h72:        pre_b = CH_CR;
                        8'h74:        pre_b = CH_TAB;
                        default:      pre_b = i_byte;
                    endcase
                end
            end
            PH_OCTAL: begin
                if (is_oct) begin
                    if (dig2 == 2'd3 || dig2 == 2'd0) begin
                        pre_v   = 1'b1;
                        pre_b   = acc2;
                        n_acc   = 8'd0;
                        n_dig   = 2'd0;
                        n_phase = PH_PLAIN;
                    end else begin
                        n_acc = acc2;
                        n_dig = dig2;
                    end
                end else begin
                    pre_v    = 1'b1;
                    pre_b    = r_acc;
                    n_acc    = 8'd0;
                    n_dig    = 2'd0;
                    do_plain = 1'b1;
                end
            end
            PH_CARET: begin
                pre_v   = 1'b1;
                pre_b   = caret_c;
                n_phase = PH_PLAIN;
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        if (pre_v) begin
            e_buf[e_cnt] = pre_b;
            e_cnt        = e_cnt + 2'd1;
            n_last_emit  = pre_b;
        end

        if (do_plain) begin
            if (i_byte == CH_BSL) begin
                n_phase = PH_BSLASH;
            end else if (i_byte == CH_CARET) begin
                n_phase = PH_CARET;
            end else begin
                e_buf[e_cnt] = i_byte;
                e_cnt        = e_cnt + 2'd1;
                n_last_emit  = i_byte;
                n_phase      = PH_PLAIN;
            end
        end

        if (i_last) begin
            // flush a pending octal value or a lone leading M; M-x ends with a CR
            if (n_phase == PH_OCTAL) begin
                e_buf[e_cnt] = n_acc;
                e_cnt        = e_cnt + 2'd1;
                n_last_emit  = n_acc;
            end else if (n_phase == PH_SAW_M) begin
                e_buf[e_cnt] = CH_M;
                e_cnt        = e_cnt + 2'd1;
                n_last_emit  = CH_M;
            end
            if (n_meta && n_last_emit != CH_CR) begin
                e_buf[e_cnt] = CH_CR;
                e_cnt        = e_cnt + 2'd1;
            end
            n_phase     = PH_START;
            n_acc       = 8'd0;
            n_dig       = 2'd0;
            n_meta      = 1'b0;
            n_last_emit = 8'd0;
        end
    end

    assign o_push        = i_accept && (e_cnt != 2'd0);
    assign o_group.bytes = e_buf;
    assign o_group.cnt   = e_cnt;
    assign o_group.last  = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_acc       <= 8'd0;
            r_dig       <= 2'd0;
            r_meta      <= 1'b0;
            r_last_emit <= 8'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_dig       <= n_dig;
            r_meta      <= n_meta;
            r_last_emit <= n_last_emit;
        end
    end

endmodule

`default_nettype wire

@@ rtl/esu_queue.sv @@
// ----------------------------------------------------------------------------
// esu_queue
// Short FIFO of result groups between decoder and serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module esu_queue import esu_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_group      i_group,
    input  wire logic   i_pop,
    output t_group      o_head,
    output logic        o_empty,
    output logic        o_full
);

    t_group               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, r_rd;
    logic [Q_CNT_W-1:0]   r_cnt, n_cnt;
    logic                 do_push, do_pop;

    assign o_empty = (r_cnt == Q_CNT_W'(0));
    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop)      n_cnt = r_cnt + Q_CNT_W'(1);
        else if (do_pop && !do_push) n_cnt = r_cnt - Q_CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + Q_PTR_W'(1);
            if (do_pop)  r_rd <= r_rd + Q_PTR_W'(1);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_group;
    end

endmodule

`default_nettype wire

@@ rtl/esu_back.sv @@
// ----------------------------------------------------------------------------
// esu_back
// Serializer: sends the head group's words one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module esu_back import esu_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_group      i_head,
    input  wire logic   i_empty,
    input  wire logic   i_stall,
    output logic        o_pop,
    output logic        o_valid,
    output logic [7:0]  o_byte,
    output logic        o_run_end,
    output logic        o_string_end
);

    logic [1:0] r_idx;
    logic       is_final;
    logic       take;

    assign o_valid      = !i_empty;
    assign o_byte       = i_head.bytes[r_idx];
    assign is_final     = (r_idx == (i_head.cnt - 2'd1));
    assign o_run_end    = is_final;
    assign o_string_end = is_final && i_head.last;
    assign take         = o_valid && !i_stall;
    assign o_pop        = take && is_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= is_final ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/escape_sequence_unescaper.sv @@
// ----------------------------------------------------------------------------
// escape_sequence_unescaper
// Decodes M-, backslash, octal and caret escapes from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one raw word (i_in_byte)
//   plus i_in_last, which marks the final word of a string. A word is taken
//   on a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall carry one decoded word with
//   o_out_run_end (last word caused by one input word) and o_out_string_end
//   (final decoded word of the string).
//   Path: the decoded group enters the queue as the input word is taken.
//   Throughput, set by the single output port of the serializer: one
//   input word per cycle while each causes at most one output word and
//   no output stall; an input's N words (N up to 3) take the output in turn.
//   A four-group queue sits between decoder and serializer, so input keeps
//   flowing while output words wait. Words causing no output use no slot.
//   Receiver stall: the output word holds; once the queue fills, o_in_stall
//   rises. Reset (synchronous, active low) empties the queue and returns
//   the decoder to start-of-string.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escape_sequence_unescaper_defines.svh"

module escape_sequence_unescaper import esu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_run_end,
    output logic            o_out_string_end
);

    logic   in_accept;
    logic   push;
    t_group push_group;
    t_group head;
    logic   q_empty;
    logic   q_full;
    logic   pop;

    // full queue blocks input; no bypass from output stall
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // front: classify the word, update escape state, build group
    esu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_push   (push),
        .o_group  (push_group)
    );

    esu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: serialize head group onto the output channel
    esu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (q_empty),
        .i_stall      (i_out_stall),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .o_byte       (o_out_byte),
        .o_run_end    (o_out_run_end),
        .o_string_end (o_out_string_end)
    );

    // queued groups always carry at least one word
    `ESU_ASSERT_IMPL(a_head_nonempty, i_clk, i_rst_n, !q_empty, head.cnt != 2'd0)
    // string end only on the closing word of a group
    `ESU_ASSERT_IMPL(a_end_in_run, i_clk, i_rst_n, o_out_valid && o_out_string_end,
                     o_out_run_end)
    // decoder never pushes into a full queue
    `ESU_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, push, !q_full)
    // a taken non-final word leaves the queue occupied
    `ESU_ASSERT_NEXT(a_run_stays, i_clk, i_rst_n,
                     o_out_valid && !i_out_stall && !o_out_run_end, o_out_valid)

endmodule

`default_nettype wire
